>>> src/tms_pkg.sv
// Shared types and constants of the tone sequencer.
package tms_pkg;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_LOAD    = 3'd1,
        OP_QMELODY = 3'd2,
        OP_QBEEP   = 3'd3,
        OP_QMUTE   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_MELODY = 2'd1,
        MODE_BEEP   = 2'd2,
        MODE_MUTE   = 2'd3
    } t_mode;

    localparam logic [3:0]  VOLUME_MAX   = 4'd10;
    localparam logic [3:0]  VOLUME_MIN   = 4'd1;
    localparam logic [15:0] BEEP_DEFAULT = 16'd100;
    localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] len;
    } t_tone_entry;

    typedef struct packed {
        logic [15:0] drive_freq;
        logic [3:0]  drive_volume;
        logic        sounding;
        logic [1:0]  play_mode;
    } t_result;

endpackage

>>> src/tms_store.sv
// Tone store: one write port, one registered read port.
module tms_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  tms_pkg::t_tone_entry i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output tms_pkg::t_tone_entry o_rdata
);
    import tms_pkg::*;

    t_tone_entry r_mem [DEPTH];
    t_tone_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/tms_ctrl.sv
// Play sequencing: slot state, tick timing and tone store access.
module tms_ctrl #(
    parameter int STORE_DEPTH = 32,
    parameter int AW          = 5,
    parameter int GAP_MS      = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [2:0]           i_op,
    input  logic [4:0]           i_tone_index,
    input  logic [15:0]          i_tone_freq,
    input  logic [15:0]          i_tone_length,
    input  logic [4:0]           i_melody_start,
    input  logic [5:0]           i_tone_count,
    input  logic [7:0]           i_repeat_limit,
    input  logic                 i_instant,
    input  logic [15:0]          i_beep_period,
    input  logic [15:0]          i_beep_duty,
    input  logic                 i_cfg_wr_en,
    input  logic [3:0]           i_cfg_wr_data,
    output logic                 o_st_we,
    output logic [AW-1:0]        o_st_waddr,
    output tms_pkg::t_tone_entry o_st_wdata,
    output logic                 o_st_re,
    output logic [AW-1:0]        o_st_raddr,
    input  tms_pkg::t_tone_entry i_st_rdata,
    output logic                 o_res_valid,
    output tms_pkg::t_result     o_res
);
    import tms_pkg::*;

    // 5-bit addresses folded onto the store depth
    typedef logic [AW-1:0] t_mod_tab [32];

    function automatic t_mod_tab mod_tab_f();
        t_mod_tab tab;
        for (int i = 0; i < 32; i++) begin
            tab[i] = AW'(i % STORE_DEPTH);
        end
        return tab;
    endfunction

    localparam t_mod_tab MOD_TAB = mod_tab_f();

    t_op op;
    assign op = t_op'(i_op);

    logic          r_busy,       n_busy;
    logic          r_fill,       n_fill;
    t_mode         r_cur_mode,   n_cur_mode;
    logic [AW-1:0] r_cur_start,  n_cur_start;
    logic [5:0]    r_cur_count,  n_cur_count;
    logic [7:0]    r_cur_repeat, n_cur_repeat;
    t_mode         r_q_mode,     n_q_mode;
    logic [AW-1:0] r_q_start,    n_q_start;
    logic [5:0]    r_q_count,    n_q_count;
    logic [7:0]    r_q_repeat,   n_q_repeat;
    logic [15:0]   r_beep_freq,  n_beep_freq;
    logic [15:0]   r_beep_on,    n_beep_on;
    logic [15:0]   r_beep_off,   n_beep_off;
    logic [15:0]   r_pend_freq,  n_pend_freq;
    logic [15:0]   r_pend_on,    n_pend_on;
    logic [15:0]   r_pend_off,   n_pend_off;
    logic [5:0]    r_pos,        n_pos;
    logic [15:0]   r_elapsed,    n_elapsed;
    logic [7:0]    r_plays,      n_plays;
    logic [15:0]   r_out_freq,   n_out_freq;
    logic          r_out_on,     n_out_on;
    logic [3:0]    r_out_vol,    n_out_vol;
    logic [3:0]    r_volume,     n_volume;
    logic [AW-1:0] r_addr,       n_addr;
    logic [15:0]   r_cur_len,    n_cur_len;

    logic [15:0]   e1;
    logic [5:0]    p1;
    logic [7:0]    pd;
    logic [15:0]   len_cur;
    logic [16:0]   gap_sum;
    logic [AW-1:0] addr_inc;
    logic          do_start;
    logic          drive;
    logic [5:0]    drive_pos;
    logic [AW-1:0] drive_addr;
    logic [AW-1:0] load_addr;
    logic [15:0]   freq_now;
    logic          snd;

    assign addr_inc  = (r_addr == AW'(STORE_DEPTH - 1)) ? '0 : r_addr + 1'b1;
    assign e1        = (r_elapsed < ELAPSED_MAX) ? r_elapsed + 16'd1 : r_elapsed;
    assign p1        = r_pos + 6'd1;
    assign pd        = r_plays + 8'd1;
    assign gap_sum   = {1'b0, e1} + 17'(GAP_MS);
    assign load_addr = MOD_TAB[i_tone_index];

    always_comb begin
        unique case (r_cur_mode)
            MODE_MELODY: len_cur = r_cur_len;
            MODE_BEEP:   len_cur = (r_pos == 6'd0) ? r_beep_on : r_beep_off;
            default:     len_cur = 16'd0;
        endcase
    end

    always_comb begin
        n_busy       = i_accept;
        n_fill       = 1'b0;
        n_cur_mode   = r_cur_mode;
        n_cur_start  = r_cur_start;
        n_cur_count  = r_cur_count;
        n_cur_repeat = r_cur_repeat;
        n_q_mode     = r_q_mode;
        n_q_start    = r_q_start;
        n_q_count    = r_q_count;
        n_q_repeat   = r_q_repeat;
        n_beep_freq  = r_beep_freq;
        n_beep_on    = r_beep_on;
        n_beep_off   = r_beep_off;
        n_pend_freq  = r_pend_freq;
        n_pend_on    = r_pend_on;
        n_pend_off   = r_pend_off;
        n_pos        = r_pos;
        n_elapsed    = r_elapsed;
        n_plays      = r_plays;
        n_out_freq   = r_out_freq;
        n_out_on     = r_out_on;
        n_out_vol    = r_out_vol;
        n_volume     = r_volume;
        n_addr       = r_addr;
        n_cur_len    = r_cur_len;
        do_start     = 1'b0;
        drive        = 1'b0;
        drive_pos    = r_pos;
        drive_addr   = r_addr;
        o_st_we      = 1'b0;
        o_st_waddr   = load_addr;
        o_st_wdata   = '{freq: i_tone_freq, len: i_tone_length};
        o_st_re      = 1'b0;
        o_st_raddr   = r_addr;

        if (i_cfg_wr_en && i_cfg_wr_data >= VOLUME_MIN && i_cfg_wr_data <= VOLUME_MAX) begin
            n_volume = i_cfg_wr_data;
        end

        // fill step: melody entry read back from the store
        if (r_fill) begin
            n_out_freq = i_st_rdata.freq;
            n_cur_len  = i_st_rdata.len;
        end

        if (i_accept) begin
            unique case (op)
                OP_TICK: begin
                    if (r_cur_mode == MODE_NONE) begin
                        do_start = 1'b1;
                    end else begin
                        n_elapsed = e1;
                        if (len_cur == 16'd0) begin
                            do_start = 1'b1;
                        end else if (e1 >= len_cur) begin
                            n_pos = p1;
                            if (p1 < r_cur_count) begin
                                n_elapsed  = 16'd0;
                                drive      = 1'b1;
                                drive_pos  = p1;
                                drive_addr = addr_inc;
                            end else begin
                                n_plays = pd;
                                if (r_cur_repeat == 8'd0 || pd < r_cur_repeat) begin
                                    if (r_cur_repeat == 8'd0 && r_q_mode != MODE_NONE) begin
                                        do_start = 1'b1;
                                    end else begin
                                        n_pos      = 6'd0;
                                        n_elapsed  = 16'd0;
                                        drive      = 1'b1;
                                        drive_pos  = 6'd0;
                                        drive_addr = r_cur_start;
                                    end
                                end else begin
                                    n_cur_mode = MODE_NONE;
                                    n_out_on   = 1'b0;
                                    do_start   = 1'b1;
                                end
                            end
                        end else if (gap_sum >= {1'b0, len_cur}) begin
                            n_out_on = 1'b0;
                        end
                    end
                end
                OP_LOAD: begin
                    o_st_we = 1'b1;
                    // keep the cached length of the playing entry coherent
                    if (r_cur_mode == MODE_MELODY && load_addr == r_addr) begin
                        n_cur_len = i_tone_length;
                    end
                end
                OP_QMELODY: begin
                    n_q_mode   = MODE_MELODY;
                    n_q_start  = MOD_TAB[i_melody_start];
                    n_q_count  = i_tone_count;
                    n_q_repeat = i_repeat_limit;
                    do_start   = i_instant;
                end
                OP_QBEEP: begin
                    n_pend_freq = i_tone_freq;
                    n_pend_on   = i_beep_duty;
                    n_pend_off  = (i_beep_period > i_beep_duty) ?
                                  i_beep_period - i_beep_duty : 16'd0;
                    n_q_mode    = MODE_BEEP;
                    n_q_start   = '0;
                    n_q_count   = 6'd2;
                    n_q_repeat  = 8'd0;
                end
                OP_QMUTE: begin
                    n_q_mode   = MODE_MUTE;
                    n_q_start  = '0;
                    n_q_count  = 6'd1;
                    n_q_repeat = 8'd0;
                    do_start   = i_instant;
                end
                default: begin
                end
            endcase

            if (do_start && n_q_mode != MODE_NONE) begin
                n_cur_mode   = n_q_mode;
                n_cur_start  = n_q_start;
                n_cur_count  = n_q_count;
                n_cur_repeat = n_q_repeat;
                if (n_q_mode == MODE_BEEP) begin
                    n_beep_freq = n_pend_freq;
                    n_beep_on   = n_pend_on;
                    n_beep_off  = n_pend_off;
                end
                n_q_mode   = MODE_NONE;
                n_pos      = 6'd0;
                n_elapsed  = 16'd0;
                n_plays    = 8'd0;
                drive      = 1'b1;
                drive_pos  = 6'd0;
                drive_addr = n_cur_start;
            end

            if (drive) begin
                n_out_on  = 1'b1;
                n_out_vol = r_volume;
                n_addr    = drive_addr;
                unique case (n_cur_mode)
                    MODE_MELODY: begin
                        o_st_re    = 1'b1;
                        o_st_raddr = drive_addr;
                        n_fill     = 1'b1;
                    end
                    MODE_BEEP: n_out_freq = (drive_pos == 6'd0) ? n_beep_freq : 16'd0;
                    default:   n_out_freq = 16'd0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_fill       <= 1'b0;
            r_cur_mode   <= MODE_NONE;
            r_cur_start  <= '0;
            r_cur_count  <= 6'd0;
            r_cur_repeat <= 8'd0;
            r_q_mode     <= MODE_NONE;
            r_q_start    <= '0;
            r_q_count    <= 6'd0;
            r_q_repeat   <= 8'd0;
            r_beep_freq  <= BEEP_DEFAULT;
            r_beep_on    <= BEEP_DEFAULT;
            r_beep_off   <= BEEP_DEFAULT;
            r_pend_freq  <= BEEP_DEFAULT;
            r_pend_on    <= BEEP_DEFAULT;
            r_pend_off   <= BEEP_DEFAULT;
            r_pos        <= 6'd0;
            r_elapsed    <= 16'd0;
            r_plays      <= 8'd0;
            r_out_freq   <= 16'd0;
            r_out_on     <= 1'b0;
            r_out_vol    <= VOLUME_MAX;
            r_volume     <= VOLUME_MAX;
            r_addr       <= '0;
            r_cur_len    <= 16'd0;
        end else begin
            r_busy       <= n_busy;
            r_fill       <= n_fill;
            r_cur_mode   <= n_cur_mode;
            r_cur_start  <= n_cur_start;
            r_cur_count  <= n_cur_count;
            r_cur_repeat <= n_cur_repeat;
            r_q_mode     <= n_q_mode;
            r_q_start    <= n_q_start;
            r_q_count    <= n_q_count;
            r_q_repeat   <= n_q_repeat;
            r_beep_freq  <= n_beep_freq;
            r_beep_on    <= n_beep_on;
            r_beep_off   <= n_beep_off;
            r_pend_freq  <= n_pend_freq;
            r_pend_on    <= n_pend_on;
            r_pend_off   <= n_pend_off;
            r_pos        <= n_pos;
            r_elapsed    <= n_elapsed;
            r_plays      <= n_plays;
            r_out_freq   <= n_out_freq;
            r_out_on     <= n_out_on;
            r_out_vol    <= n_out_vol;
            r_volume     <= n_volume;
            r_addr       <= n_addr;
            r_cur_len    <= n_cur_len;
        end
    end

    // result reflects the drive after the step, with read data folded in
    assign freq_now    = r_fill ? i_st_rdata.freq : r_out_freq;
    assign snd         = r_out_on && (freq_now != 16'd0);
    assign o_res_valid = r_busy;
    assign o_res       = '{drive_freq:   snd ? freq_now : 16'd0,
                           drive_volume: snd ? r_out_vol : 4'd0,
                           sounding:     snd,
                           play_mode:    r_cur_mode};

endmodule

>>> src/tms_outq.sv
// Output register with one skid entry.
module tms_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  tms_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_valid,
    output tms_pkg::t_result o_res,
    output logic             o_skid_full
);
    import tms_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_res_valid) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid) begin
            if (!r_out_valid || take) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end else if (take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_res       = r_out;
    assign o_skid_full = r_skid_valid;

endmodule

>>> src/tone_melody_beep_sequencer.sv
// Top level of the buzzer tone sequencer.
//
//   channel   dir   handshake                  payload
//   request   in    i_valid / o_stall          i_op .. i_beep_duty
//   result    out   o_valid / i_stall          o_drive_freq .. o_play_mode
//   config    in    i_cfg_wr_en                i_cfg_wr_data (volume)
//
// Each request is handled in steps: the first updates the play state and issues the
// tone store access, the second captures the store read data and forms the result.
// No new request is taken while the previous one forms its result; o_stall is also high
// while the skid entry behind the output register holds a result.
// Reset is synchronous; the tone store is not cleared and needs no clearing pass.
// A stalled result holds in the output register; one more result fits in the skid.
module tone_melody_beep_sequencer #(
    parameter int STORE_DEPTH = 32,
    parameter int GAP_MS      = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [4:0]  i_tone_index,
    input  logic [15:0] i_tone_freq,
    input  logic [15:0] i_tone_length,
    input  logic [4:0]  i_melody_start,
    input  logic [5:0]  i_tone_count,
    input  logic [7:0]  i_repeat_limit,
    input  logic        i_instant,
    input  logic [15:0] i_beep_period,
    input  logic [15:0] i_beep_duty,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_drive_freq,
    output logic [3:0]  o_drive_volume,
    output logic        o_sounding,
    output logic [1:0]  o_play_mode
);
    import tms_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic          accept;
    logic          res_valid;
    logic          skid_full;
    t_result       res;
    t_result       out_res;
    logic          st_we;
    logic [AW-1:0] st_waddr;
    t_tone_entry   st_wdata;
    logic          st_re;
    logic [AW-1:0] st_raddr;
    t_tone_entry   st_rdata;

    assign o_stall = res_valid || skid_full;
    assign accept  = i_valid && !o_stall;

    tms_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    tms_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW),
        .GAP_MS      (GAP_MS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_op           (i_op),
        .i_tone_index   (i_tone_index),
        .i_tone_freq    (i_tone_freq),
        .i_tone_length  (i_tone_length),
        .i_melody_start (i_melody_start),
        .i_tone_count   (i_tone_count),
        .i_repeat_limit (i_repeat_limit),
        .i_instant      (i_instant),
        .i_beep_period  (i_beep_period),
        .i_beep_duty    (i_beep_duty),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_st_we        (st_we),
        .o_st_waddr     (st_waddr),
        .o_st_wdata     (st_wdata),
        .o_st_re        (st_re),
        .o_st_raddr     (st_raddr),
        .i_st_rdata     (st_rdata),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    tms_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_res       (out_res),
        .o_skid_full (skid_full)
    );

    assign o_drive_freq   = out_res.drive_freq;
    assign o_drive_volume = out_res.drive_volume;
    assign o_sounding     = out_res.sounding;
    assign o_play_mode    = out_res.play_mode;

    // every accepted request yields its result in the following cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> res_valid)
        else $error("accepted request produced no result");

    // no request is taken while the store read of the previous one completes
    a_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !accept)
        else $error("request accepted during second cycle");

    // a result is never formed while the skid entry is occupied
    a_skid_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res_valid && skid_full))
        else $error("result formed with skid entry full");

    // a sounding tone always carries a frequency and a volume
    a_sound_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sounding) |-> (o_drive_freq != 16'd0 && o_drive_volume != 4'd0))
        else $error("sounding result without frequency or volume");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the buzzer tone sequencer: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

module testbench;
    import tms_pkg::*;

    localparam int STORE_DEPTH     = 32;
    localparam int GAP_MS          = 20;
    localparam int QUIET_LIMIT     = 2000;
    localparam int PHASES          = 8;
    localparam int PHASE_REQS      = 73;
    localparam int LONG_TONE_TICKS = 40;
    localparam int MAX_REPORTS     = 10;

    localparam logic [2:0] OP_SPARE_LO     = 3'd5;
    localparam logic [2:0] OP_SPARE_HI     = 3'd7;
    localparam logic [4:0] LONG_TONE_ENTRY = 5'd16;

    typedef struct {
        logic [2:0]  op;
        logic [4:0]  index;
        logic [15:0] freq;
        logic [15:0] length;
        logic [4:0]  start;
        logic [5:0]  count;
        logic [7:0]  rep_limit;
        logic        instant;
        logic [15:0] period;
        logic [15:0] duty;
    } t_tone_req;

    class t_tone_scoreboard;
        t_tone_entry tone_mem [STORE_DEPTH];
        logic [3:0]  volume, out_vol;
        t_mode       cur_mode, q_mode;
        logic [4:0]  cur_start, q_start;
        logic [5:0]  cur_count, q_count, tone_pos;
        logic [7:0]  cur_repeat, q_repeat, plays_done;
        logic [15:0] beep_freq, beep_on, beep_off;
        logic [15:0] pend_freq, pend_on, pend_off;
        logic [15:0] elapsed, out_freq;
        logic        out_on;
        t_result     expected_drive [$];
        int          errors, checked;
        int          n_tick, n_load, n_melody, n_beep, n_mute, n_spare;

        function new();
            foreach (tone_mem[i]) tone_mem[i] = '0;
            volume = VOLUME_MAX;
            out_vol = VOLUME_MAX;
            cur_mode = MODE_NONE;
            q_mode = MODE_NONE;
            cur_start = '0; cur_count = '0; cur_repeat = '0;
            q_start = '0; q_count = '0; q_repeat = '0;
            beep_freq = BEEP_DEFAULT; beep_on = BEEP_DEFAULT; beep_off = BEEP_DEFAULT;
            pend_freq = BEEP_DEFAULT; pend_on = BEEP_DEFAULT; pend_off = BEEP_DEFAULT;
            tone_pos = '0; elapsed = '0; plays_done = '0;
            out_freq = '0;
            out_on = 1'b0;
        endfunction

        function void write_volume(input logic [3:0] v);
            if (v >= VOLUME_MIN && v <= VOLUME_MAX)
                volume = v;
        endfunction

        function void tone_at(input logic [5:0] pos, output logic [15:0] f,
                              output logic [15:0] l);
            logic [4:0] a;
            a = cur_start + pos[4:0];
            case (cur_mode)
                MODE_MELODY: begin
                    f = tone_mem[a].freq;
                    l = tone_mem[a].len;
                end
                MODE_BEEP: begin
                    f = (pos == 0) ? beep_freq : 16'd0;
                    l = (pos == 0) ? beep_on : beep_off;
                end
                default: begin
                    f = '0;
                    l = '0;
                end
            endcase
        endfunction

        function void drive_tone(input logic [5:0] pos);
            logic [15:0] f, l;
            tone_at(pos, f, l);
            out_freq = f;
            out_on = 1'b1;
            out_vol = volume;
        endfunction

        function void start_queued_play();
            if (q_mode == MODE_NONE)
                return;
            cur_mode = q_mode;
            cur_start = q_start;
            cur_count = q_count;
            cur_repeat = q_repeat;
            if (cur_mode == MODE_BEEP) begin
                beep_freq = pend_freq;
                beep_on = pend_on;
                beep_off = pend_off;
            end
            q_mode = MODE_NONE;
            tone_pos = '0;
            elapsed = '0;
            plays_done = '0;
            drive_tone(6'd0);
        endfunction

        // one millisecond of play
        function void advance_ms();
            logic [15:0] f, l;
            if (cur_mode == MODE_NONE) begin
                start_queued_play();
                return;
            end
            if (elapsed != ELAPSED_MAX)
                elapsed++;
            tone_at(tone_pos, f, l);
            if (l == 0) begin
                if (q_mode != MODE_NONE)
                    start_queued_play();
                return;
            end
            if (elapsed >= l) begin
                tone_pos++;
                if (tone_pos < cur_count) begin
                    elapsed = '0;
                    drive_tone(tone_pos);
                    return;
                end
                plays_done++;
                if (cur_repeat == 0 || plays_done < cur_repeat) begin
                    // endless play gives way to a queued one at the end of a pass
                    if (cur_repeat == 0 && q_mode != MODE_NONE) begin
                        start_queued_play();
                        return;
                    end
                    tone_pos = '0;
                    elapsed = '0;
                    drive_tone(6'd0);
                end else begin
                    cur_mode = MODE_NONE;
                    out_on = 1'b0;
                    start_queued_play();
                end
            end else if (int'(elapsed) + GAP_MS >= int'(l)) begin
                out_on = 1'b0;
            end
        endfunction

        function void note_request(input t_tone_req r);
            t_result e;
            logic    snd;
            case (r.op)
                OP_TICK: begin
                    n_tick++;
                    advance_ms();
                end
                OP_LOAD: begin
                    n_load++;
                    tone_mem[r.index].freq = r.freq;
                    tone_mem[r.index].len = r.length;
                end
                OP_QMELODY: begin
                    n_melody++;
                    q_mode = MODE_MELODY;
                    q_start = r.start;
                    q_count = r.count;
                    q_repeat = r.rep_limit;
                    if (r.instant)
                        start_queued_play();
                end
                OP_QBEEP: begin
                    n_beep++;
                    pend_freq = r.freq;
                    pend_on = r.duty;
                    pend_off = (r.period > r.duty) ? r.period - r.duty : 16'd0;
                    q_mode = MODE_BEEP;
                    q_start = '0;
                    q_count = 6'd2;
                    q_repeat = '0;
                end
                OP_QMUTE: begin
                    n_mute++;
                    q_mode = MODE_MUTE;
                    q_start = '0;
                    q_count = 6'd1;
                    q_repeat = '0;
                    if (r.instant)
                        start_queued_play();
                end
                default: n_spare++;
            endcase
            snd = out_on && (out_freq != 0);
            e.drive_freq = snd ? out_freq : 16'd0;
            e.drive_volume = snd ? out_vol : 4'd0;
            e.sounding = snd;
            e.play_mode = cur_mode;
            expected_drive.push_back(e);
        endfunction

        function void check_result(input t_result got);
            t_result e;
            if (expected_drive.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result: freq %0d vol %0d snd %0d mode %0d",
                             $time, got.drive_freq, got.drive_volume, got.sounding,
                             got.play_mode);
                return;
            end
            e = expected_drive.pop_front();
            checked++;
            if (got.drive_freq !== e.drive_freq || got.drive_volume !== e.drive_volume ||
                got.sounding !== e.sounding || got.play_mode !== e.play_mode) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: result %0d mismatch (freq vol snd mode)", $time, checked);
                    $display("    exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                             e.drive_freq, e.drive_volume, e.sounding, e.play_mode,
                             got.drive_freq, got.drive_volume, got.sounding, got.play_mode);
                end
            end
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction

        function bit failed();
            return (errors != 0) || (expected_drive.size() != 0);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_op;
    logic [4:0]  i_tone_index;
    logic [15:0] i_tone_freq;
    logic [15:0] i_tone_length;
    logic [4:0]  i_melody_start;
    logic [5:0]  i_tone_count;
    logic [7:0]  i_repeat_limit;
    logic        i_instant;
    logic [15:0] i_beep_period;
    logic [15:0] i_beep_duty;
    logic        i_cfg_wr_en;
    logic [3:0]  i_cfg_wr_data;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_drive_freq;
    logic [3:0]  o_drive_volume;
    logic        o_sounding;
    logic [1:0]  o_play_mode;

    t_tone_scoreboard sb;
    t_tone_req        seen_req;
    bit               loaded [STORE_DEPTH];
    bit               tx_idle_en;
    bit               rx_idle_en;
    int               rx_hold_req;
    int               reqs_sent;
    int               quiet_cycles;

    tone_melody_beep_sequencer #(
        .STORE_DEPTH(STORE_DEPTH),
        .GAP_MS     (GAP_MS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_tone_index  (i_tone_index),
        .i_tone_freq   (i_tone_freq),
        .i_tone_length (i_tone_length),
        .i_melody_start(i_melody_start),
        .i_tone_count  (i_tone_count),
        .i_repeat_limit(i_repeat_limit),
        .i_instant     (i_instant),
        .i_beep_period (i_beep_period),
        .i_beep_duty   (i_beep_duty),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_drive_freq  (o_drive_freq),
        .o_drive_volume(o_drive_volume),
        .o_sounding    (o_sounding),
        .o_play_mode   (o_play_mode)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // fields the op does not use still get random values
    function automatic t_tone_req blank_req(input logic [2:0] op);
        t_tone_req r;
        r.op = op;
        r.index = 5'($urandom_range(0, 31));
        r.freq = 16'($urandom_range(0, 65535));
        r.length = 16'($urandom_range(0, 65535));
        r.start = 5'($urandom_range(0, 31));
        r.count = 6'($urandom_range(0, 63));
        r.rep_limit = 8'($urandom_range(0, 255));
        r.instant = 1'($urandom_range(0, 1));
        r.period = 16'($urandom_range(0, 65535));
        r.duty = 16'($urandom_range(0, 65535));
        return r;
    endfunction

    function automatic logic [15:0] rand_freq();
        return ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    endfunction

    function automatic logic [15:0] rand_len();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'($urandom_range(GAP_MS - 1, GAP_MS + 1));
            2:       return 16'($urandom_range(40, 120));
            default: return 16'($urandom_range(1, 30));
        endcase
    endfunction

    function automatic logic [15:0] rand_beep_ms();
        return ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 50));
    endfunction

    task automatic send(input t_tone_req r);
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= r.op;
        i_tone_index <= r.index;
        i_tone_freq <= r.freq;
        i_tone_length <= r.length;
        i_melody_start <= r.start;
        i_tone_count <= r.count;
        i_repeat_limit <= r.rep_limit;
        i_instant <= r.instant;
        i_beep_period <= r.period;
        i_beep_duty <= r.duty;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        if (r.op <= OP_QMUTE)
            reqs_sent++;
    endtask

    task automatic ticks(input int n);
        repeat (n) send(blank_req(OP_TICK));
    endtask

    task automatic do_load(input logic [4:0] idx, input logic [15:0] f, input logic [15:0] l);
        t_tone_req r;
        r = blank_req(OP_LOAD);
        r.index = idx;
        r.freq = f;
        r.length = l;
        send(r);
        loaded[idx] = 1'b1;
    endtask

    // entries the melody will read are written first, never-written entries are never played
    task automatic do_melody(input logic [4:0] start, input logic [5:0] count,
                             input logic [7:0] rep, input logic inst);
        t_tone_req  r;
        int         span;
        logic [4:0] a;
        span = (count == 0) ? 1 : int'(count);
        for (int p = 0; p < span; p++) begin
            a = 5'(int'(start) + p);
            if (!loaded[a])
                do_load(a, rand_freq(), rand_len());
        end
        r = blank_req(OP_QMELODY);
        r.start = start;
        r.count = count;
        r.rep_limit = rep;
        r.instant = inst;
        send(r);
    endtask

    task automatic do_beep(input logic [15:0] f, input logic [15:0] period,
                           input logic [15:0] duty, input logic inst);
        t_tone_req r;
        r = blank_req(OP_QBEEP);
        r.freq = f;
        r.period = period;
        r.duty = duty;
        r.instant = inst;
        send(r);
    endtask

    task automatic do_mute(input logic inst);
        t_tone_req r;
        r = blank_req(OP_QMUTE);
        r.instant = inst;
        send(r);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic set_volume(input logic [3:0] v);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.write_volume(v);
    endtask

    task automatic random_sequence();
        int         kind;
        logic [5:0] count;
        logic [7:0] rep;
        kind = $urandom_range(0, 19);
        if (kind < 9) begin
            repeat ($urandom_range(0, 3))
                do_load(5'($urandom_range(0, 31)), rand_freq(), rand_len());
            case ($urandom_range(0, 9))
                0:       count = 6'd0;
                1:       count = 6'($urandom_range(7, 63));
                default: count = 6'($urandom_range(1, 6));
            endcase
            rep = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 3));
            do_melody(5'($urandom_range(0, 31)), count, rep, 1'($urandom_range(0, 1)));
        end else if (kind < 13) begin
            do_beep(rand_freq(), rand_beep_ms(), rand_beep_ms(), 1'($urandom_range(0, 1)));
        end else if (kind < 15) begin
            do_mute(1'($urandom_range(0, 1)));
        end else begin
            // noise: any op, spare codes included
            repeat ($urandom_range(1, 4)) begin
                case (3'($urandom_range(0, 7)))
                    OP_TICK:    ticks(1);
                    OP_LOAD:    do_load(5'($urandom_range(0, 31)), rand_freq(), rand_len());
                    OP_QMELODY: do_melody(5'($urandom_range(0, 31)),
                                          6'($urandom_range(0, 8)),
                                          8'($urandom_range(0, 255)),
                                          1'($urandom_range(0, 1)));
                    OP_QBEEP:   do_beep(rand_freq(), rand_beep_ms(), rand_beep_ms(),
                                        1'($urandom_range(0, 1)));
                    OP_QMUTE:   do_mute(1'($urandom_range(0, 1)));
                    default:    send(blank_req(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))));
                endcase
            end
        end
        ticks($urandom_range(3, 60));
    endtask

    // receiver side: random stall bursts plus an occasional long hold-off
    initial begin
        int burst;
        int hold;
        burst = 0;
        hold = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req > 0) begin
                hold = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                hold--;
            end else if (burst > 0) begin
                i_stall <= 1'b1;
                burst--;
            end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                burst = $urandom_range(0, 6);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_stall === 1'b0) begin
                seen_req.op = i_op;
                seen_req.index = i_tone_index;
                seen_req.freq = i_tone_freq;
                seen_req.length = i_tone_length;
                seen_req.start = i_melody_start;
                seen_req.count = i_tone_count;
                seen_req.rep_limit = i_repeat_limit;
                seen_req.instant = i_instant;
                seen_req.period = i_beep_period;
                seen_req.duty = i_beep_duty;
                sb.note_request(seen_req);
            end
            if (o_valid === 1'b1 && !i_stall)
                sb.check_result({o_drive_freq, o_drive_volume, o_sounding, o_play_mode});
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        quiet_cycles = 0;
        do @(posedge i_clk); while (quiet_cycles < QUIET_LIMIT);
        $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, sb.pending());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [3:0] vol_plan [PHASES];
        int         target;
        vol_plan = '{4'd1, 4'd10, 4'd0, 4'd6, 4'd15, 4'd11, 4'd1, 4'd9};
        sb = new();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        rx_hold_req = 0;
        reqs_sent = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_op <= OP_TICK;
        i_tone_index <= '0;
        i_tone_freq <= '0;
        i_tone_length <= '0;
        i_melody_start <= '0;
        i_tone_count <= '0;
        i_repeat_limit <= '0;
        i_instant <= 1'b0;
        i_beep_period <= '0;
        i_beep_duty <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_volume(4'd7);

        // directed: idle tick, spare ops, store loads
        ticks(1);
        send(blank_req(OP_SPARE_LO));
        send(blank_req(OP_SPARE_HI));
        do_load(5'd0, 16'd0, 16'd5);
        do_load(5'd1, 16'd1000, 16'd10);
        do_load(5'd2, 16'd2000, 16'd0);
        do_load(5'd30, 16'd3000, 16'd25);
        do_load(5'd31, 16'd1500, 16'd22);
        do_load(LONG_TONE_ENTRY, 16'hFFFF, 16'hFFFF);
        // zero-count melody queued with nothing playing starts on the next tick
        do_melody(5'd0, 6'd0, 8'd1, 1'b0);
        ticks(7);
        // address wrap 31 -> 0, two passes
        do_melody(5'd31, 6'd2, 8'd2, 1'b1);
        ticks(60);
        // tone shorter than the gap, then a holding entry
        do_melody(5'd1, 6'd2, 8'd0, 1'b1);
        ticks(14);
        // beep ignores instant; queued play releases the hold on the next tick
        do_beep(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        ticks(3);
        do_mute(1'b1);
        ticks(1);
        do_beep(16'd500, 16'd30, 16'd40, 1'b0);
        ticks(45);
        do_beep(16'd700, 16'd0, 16'd0, 1'b0);
        ticks(3);
        do_mute(1'b0);
        ticks(2);
        // endless melody hands over to the queued one at the end of its pass
        do_melody(5'd31, 6'd1, 8'd0, 1'b1);
        ticks(5);
        do_melody(5'd30, 6'd1, 8'd1, 1'b0);
        ticks(30);

        // full-scale tone that outlasts its ticks, then cut off by mute
        do_melody(LONG_TONE_ENTRY, 6'd1, 8'd1, 1'b1);
        ticks(LONG_TONE_TICKS);
        do_mute(1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            set_volume(vol_plan[ph]);
            if (ph == PHASES - 1) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            if (ph == 2 || ph == 5)
                rx_hold_req = 40 + 10 * ph;
            target = reqs_sent + PHASE_REQS;
            while (reqs_sent < target)
                random_sequence();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d requests: %0d ticks, %0d loads, %0d melodies, %0d beeps,",
                 reqs_sent, sb.n_tick, sb.n_load, sb.n_melody, sb.n_beep);
        $display("%0d mutes, %0d spare ops; %0d results checked, %0d errors",
                 sb.n_mute, sb.n_spare, sb.checked, sb.errors);
        if (sb.failed())
            $display("== FAIL ==");
        else
            $display("== PASS ==");
        $finish;
    end

endmodule
